[rtl/pressure_temperature_compensation_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pressure/temperature compensation core
// Property wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc: next-cycle check failed");
`else
`define PTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared beat types, register indexes, limits and helpers for the
// pressure/temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MODEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SENS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SENS_TC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFFSET_TC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TREF      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TEMPSENS  = 3'd6;

  localparam int CFG_DATA_W = 16;

  // Temperature reference points in hundredths of a degree
  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;

  // Output saturation limits
  localparam logic signed [18:0] TEMP_MIN = {1'b1, 18'b0};
  localparam logic signed [18:0] TEMP_MAX = {1'b0, {18{1'b1}}};
  localparam logic signed [39:0] PRES_MIN = {1'b1, 39'b0};
  localparam logic signed [39:0] PRES_MAX = {1'b0, {39{1'b1}}};

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } ptc_in_t;

  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [39:0] pressure_comp;
  } ptc_out_t;

  typedef struct packed {
    logic        sensor_model;
    logic [15:0] coef_sens;
    logic [15:0] coef_offset;
    logic [15:0] coef_sens_tc;
    logic [15:0] coef_offset_tc;
    logic [15:0] coef_tref;
    logic [15:0] coef_tempsens;
  } ptc_cfg_t;

  // First-order results handed to the correction stages
  typedef struct packed {
    logic [23:0]        d1;
    logic [35:0]        t_sq;
    logic [35:0]        u_sq;
    logic               low_temp;
    logic               very_low;
    logic signed [20:0] temp;
    logic signed [40:0] sens1;
    logic signed [40:0] off1;
  } ptc_fc_t;

  // Corrected sensitivity and offset handed to the pressure stages
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [20:0] temp;
    logic signed [40:0] sens;
    logic signed [40:0] off;
  } ptc_cp_t;

  // Signed shift right by k that truncates toward zero
  function automatic logic signed [65:0] trunc_shr(input logic signed [65:0] x,
                                                   input int unsigned k);
    logic signed [65:0] bias;
    bias = x[65] ? ((66'sd1 <<< k) - 66'sd1) : 66'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

[rtl/pressure_temperature_compensation_core.sv]
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Second-order temperature compensation of raw pressure and temperature
// conversions, as an 11-stage pipeline with calibration registers.
//
//   Channel  Direction  Handshake            Beat
//   in_      input      in_valid/in_stall    raw pressure, raw temperature
//   out_     output     out_valid/out_stall  centi-degrees, pressure
//   cfg_     input      cfg_we               register index, write data
//
// Throughput is one beat per cycle while out_stall stays low; the stage
// count is set by the front (4), correction (2) and pressure (5) sections.
// Synchronous reset clears all valid bits and the calibration registers.
// Every stage advances when empty or when its successor advances, so bubbles
// close up under out_stall; in_stall rises only when all 11 stages hold beats.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_core_defines.svh"

module pressure_temperature_compensation_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ptc_pkg::ptc_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ptc_pkg::ptc_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ptc_pkg::*;

  ptc_cfg_t cfg_r;

  logic    front_ready;
  logic    fc_valid, fc_ready;
  ptc_fc_t fc_data;
  logic    cp_valid, cp_ready;
  ptc_cp_t cp_data;
  logic    out_temp_at_limit;

  // Calibration registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_MODEL:   cfg_r.sensor_model   <= cfg_wdata[0];
        CFG_COEF_SENS:      cfg_r.coef_sens      <= cfg_wdata;
        CFG_COEF_OFFSET:    cfg_r.coef_offset    <= cfg_wdata;
        CFG_COEF_SENS_TC:   cfg_r.coef_sens_tc   <= cfg_wdata;
        CFG_COEF_OFFSET_TC: cfg_r.coef_offset_tc <= cfg_wdata;
        CFG_COEF_TREF:      cfg_r.coef_tref      <= cfg_wdata;
        CFG_COEF_TEMPSENS:  cfg_r.coef_tempsens  <= cfg_wdata;
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  assign in_stall = !front_ready;

  ptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_data   (in_data),
    .out_valid (fc_valid),
    .out_ready (fc_ready),
    .out_data  (fc_data)
  );

  ptc_correct u_correct (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (fc_valid),
    .in_ready  (fc_ready),
    .in_data   (fc_data),
    .out_valid (cp_valid),
    .out_ready (cp_ready),
    .out_data  (cp_data)
  );

  ptc_pressure u_pressure (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (cp_valid),
    .in_ready  (cp_ready),
    .in_data   (cp_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

  // Flag a temperature beat sitting on either saturation limit
  assign out_temp_at_limit = (out_data.temperature_centi == TEMP_MIN)
                          || (out_data.temperature_centi == TEMP_MAX);

  // Input backs up only behind a full, stalled output
  `PTC_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
  // Temperature path never reaches its saturation limits
  `PTC_ASSERT_IMPLY(a_temp_in_range, clk, rst_n, out_valid, !out_temp_at_limit)
  // A beat held between correction and pressure sections stays put
  `PTC_ASSERT_NEXT(a_cp_beat_held, clk, rst_n, cp_valid && !cp_ready, cp_valid)

endmodule

[rtl/ptc_front.sv]
// ----------------------------------------------------------------------------
// ptc_front
// First-order compensation: dT, the coefficient products, TEMP with its
// second-order temperature term, first-order SENS/OFF and the squares.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ptc_pkg::ptc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptc_pkg::ptc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptc_pkg::ptc_fc_t  out_data
);
  import ptc_pkg::*;

  localparam int NSTG = 4;
  localparam logic signed [18:0] T_VLOW_LIM = 19'(TEMP_VLOW - TEMP_REF);
  localparam logic signed [19:0] U_OFS      = 20'(TEMP_REF - TEMP_VLOW);

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [24:0] dt;
  } s1_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [41:0] pdt6;
    logic signed [41:0] p3;
    logic signed [41:0] p4;
    logic [47:0]        dsq;
  } s2_t;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] t;
    logic signed [36:0] q3;
    logic signed [36:0] q4;
    logic [16:0]        ti_low;
    logic [16:0]        ti_high;
  } s3_t;

  logic [NSTG-1:0] vld_r, vld_nxt, en;
  s1_t     s1_r, s1_nxt;
  s2_t     s2_r, s2_nxt;
  s3_t     s3_r, s3_nxt;
  ptc_fc_t s4_r, s4_nxt;

  logic signed [49:0] dsq_w;
  logic signed [37:0] t_sq_w;
  logic signed [19:0] u_w;
  logic signed [39:0] u_sq_w;
  logic [16:0]        ti_sel;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = s4_r;

  // Stage 1: dT = D2 - C5 * 256
  always_comb begin
    s1_nxt.d1 = in_data.raw_pressure;
    s1_nxt.dt = $signed({1'b0, in_data.raw_temperature})
              - $signed({1'b0, cfg.coef_tref, 8'b0});
  end

  // Stage 2: coefficient products and dT squared
  always_comb begin
    dsq_w       = s1_r.dt * s1_r.dt;
    s2_nxt.d1   = s1_r.d1;
    s2_nxt.pdt6 = s1_r.dt * $signed({1'b0, cfg.coef_tempsens});
    s2_nxt.p3   = s1_r.dt * $signed({1'b0, cfg.coef_sens_tc});
    s2_nxt.p4   = s1_r.dt * $signed({1'b0, cfg.coef_offset_tc});
    s2_nxt.dsq  = dsq_w[47:0];
  end

  // Stage 3: truncating scale-downs and both temperature correction terms
  always_comb begin
    s3_nxt.d1 = s2_r.d1;
    s3_nxt.t  = 19'(trunc_shr(66'(s2_r.pdt6), 23));
    if (cfg.sensor_model) begin
      s3_nxt.q3      = 37'(trunc_shr(66'(s2_r.p3), 8));
      s3_nxt.q4      = 37'(trunc_shr(66'(s2_r.p4), 7));
      s3_nxt.ti_low  = 17'((52'(s2_r.dsq) * 52'd3) >> 33);
      s3_nxt.ti_high = 17'(s2_r.dsq >> 36);
    end else begin
      s3_nxt.q3      = 37'(trunc_shr(66'(s2_r.p3), 7));
      s3_nxt.q4      = 37'(trunc_shr(66'(s2_r.p4), 6));
      s3_nxt.ti_low  = 17'((52'(s2_r.dsq) * 52'd11) >> 35);
      s3_nxt.ti_high = '0;
    end
  end

  // Stage 4: TEMP, first-order SENS/OFF, squares of t and u
  always_comb begin
    t_sq_w = s3_r.t * s3_r.t;
    u_w    = 20'(s3_r.t) + U_OFS;
    u_sq_w = u_w * u_w;
    ti_sel = s3_r.t[18] ? s3_r.ti_low : s3_r.ti_high;

    s4_nxt.d1       = s3_r.d1;
    s4_nxt.t_sq     = t_sq_w[35:0];
    s4_nxt.u_sq     = u_sq_w[35:0];
    s4_nxt.low_temp = s3_r.t[18];
    s4_nxt.very_low = s3_r.t < T_VLOW_LIM;
    s4_nxt.temp     = 21'(s3_r.t) + 21'(TEMP_REF) - $signed({4'b0, ti_sel});
    if (cfg.sensor_model) begin
      s4_nxt.sens1 = $signed({10'b0, cfg.coef_sens, 15'b0}) + 41'(s3_r.q3);
      s4_nxt.off1  = $signed({9'b0, cfg.coef_offset, 16'b0}) + 41'(s3_r.q4);
    end else begin
      s4_nxt.sens1 = $signed({9'b0, cfg.coef_sens, 16'b0}) + 41'(s3_r.q3);
      s4_nxt.off1  = $signed({8'b0, cfg.coef_offset, 17'b0}) + 41'(s3_r.q4);
    end
  end

  // Clear valid bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload registers on stage advance
  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
  end

endmodule

[rtl/ptc_correct.sv]
// ----------------------------------------------------------------------------
// ptc_correct
// Second-order offset and sensitivity corrections for low, very-low and
// high temperature, applied to the first-order SENS and OFF.
// ----------------------------------------------------------------------------
module ptc_correct (
  input  logic              clk,
  input  logic              rst_n,
  input  ptc_pkg::ptc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptc_pkg::ptc_fc_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptc_pkg::ptc_cp_t  out_data
);
  import ptc_pkg::*;

  localparam int NSTG = 2;

  typedef struct packed {
    logic [23:0]        d1;
    logic signed [20:0] temp;
    logic signed [40:0] sens1;
    logic signed [40:0] off1;
    logic [39:0]        offi;
    logic [39:0]        sensi;
  } s5_t;

  logic [NSTG-1:0] vld_r, vld_nxt, en;
  s5_t     s5_r, s5_nxt;
  ptc_cp_t s6_r, s6_nxt;

  logic [41:0] t2_x, u2_x;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = s6_r;

  // Stage 5: pick the correction terms for the model and temperature band
  always_comb begin
    t2_x = 42'(in_data.t_sq);
    u2_x = 42'(in_data.u_sq);

    s5_nxt.d1    = in_data.d1;
    s5_nxt.temp  = in_data.temp;
    s5_nxt.sens1 = in_data.sens1;
    s5_nxt.off1  = in_data.off1;
    s5_nxt.offi  = '0;
    s5_nxt.sensi = '0;
    if (!cfg.sensor_model) begin
      if (in_data.low_temp) begin
        s5_nxt.offi  = 40'((t2_x * 42'd31) >> 3);
        s5_nxt.sensi = 40'((t2_x * 42'd63) >> 5);
      end
    end else if (in_data.low_temp) begin
      // Very-low band adds its own term on top of the low band
      s5_nxt.offi  = 40'(((t2_x * 42'd3) >> 1)
                   + (in_data.very_low ? u2_x * 42'd7 : 42'd0));
      s5_nxt.sensi = 40'(((t2_x * 42'd5) >> 3)
                   + (in_data.very_low ? (u2_x << 2) : 42'd0));
    end else begin
      s5_nxt.offi  = 40'(t2_x >> 4);
    end
  end

  // Stage 6: apply the corrections
  always_comb begin
    s6_nxt.d1   = s5_r.d1;
    s6_nxt.temp = s5_r.temp;
    s6_nxt.sens = s5_r.sens1 - $signed({1'b0, s5_r.sensi});
    s6_nxt.off  = s5_r.off1 - $signed({1'b0, s5_r.offi});
  end

  // Clear valid bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload registers on stage advance
  always_ff @(posedge clk) begin
    if (en[0]) s5_r <= s5_nxt;
    if (en[1]) s6_r <= s6_nxt;
  end

endmodule

[rtl/ptc_pressure.sv]
// ----------------------------------------------------------------------------
// ptc_pressure
// Pressure from D1, SENS and OFF: split 24x41 product, truncating scale-downs,
// saturation of both outputs and the output register.
// ----------------------------------------------------------------------------
module ptc_pressure (
  input  logic              clk,
  input  logic              rst_n,
  input  ptc_pkg::ptc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptc_pkg::ptc_cp_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptc_pkg::ptc_out_t out_data
);
  import ptc_pkg::*;

  localparam int NSTG = 5;

  typedef struct packed {
    logic [44:0]        pp_lo;
    logic signed [44:0] pp_hi;
    logic signed [40:0] off;
    logic signed [20:0] temp;
  } s7_t;

  typedef struct packed {
    logic signed [65:0] prod;
    logic signed [40:0] off;
    logic signed [20:0] temp;
  } s8_t;

  typedef struct packed {
    logic signed [45:0] q;
    logic signed [40:0] off;
    logic signed [20:0] temp;
  } s9_t;

  typedef struct packed {
    logic signed [46:0] p0;
    logic signed [20:0] temp;
  } s10_t;

  logic [NSTG-1:0] vld_r, vld_nxt, en;
  s7_t      s7_r, s7_nxt;
  s8_t      s8_r, s8_nxt;
  s9_t      s9_r, s9_nxt;
  s10_t     s10_r, s10_nxt;
  ptc_out_t s11_r, s11_nxt;

  logic signed [65:0] pdiv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = s11_r;

  // Stage 7: partial products of D1 against the low and high halves of SENS
  always_comb begin
    s7_nxt.pp_lo = 45'(in_data.d1) * 45'(in_data.sens[20:0]);
    s7_nxt.pp_hi = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[40:21]);
    s7_nxt.off   = in_data.off;
    s7_nxt.temp  = in_data.temp;
  end

  // Stage 8: recombine the full product
  always_comb begin
    s8_nxt.prod = (66'(s7_r.pp_hi) <<< 21) + $signed({21'b0, s7_r.pp_lo});
    s8_nxt.off  = s7_r.off;
    s8_nxt.temp = s7_r.temp;
  end

  // Stage 9: D1 * SENS / 2^21
  always_comb begin
    s9_nxt.q    = 46'(trunc_shr(s8_r.prod, 21));
    s9_nxt.off  = s8_r.off;
    s9_nxt.temp = s8_r.temp;
  end

  // Stage 10: subtract OFF
  always_comb begin
    s10_nxt.p0   = 47'(s9_r.q) - 47'(s9_r.off);
    s10_nxt.temp = s9_r.temp;
  end

  // Stage 11: final scale-down and saturation
  always_comb begin
    pdiv = cfg.sensor_model ? trunc_shr(66'(s10_r.p0), 13)
                            : trunc_shr(66'(s10_r.p0), 15);
    if (pdiv < 66'(PRES_MIN)) begin
      s11_nxt.pressure_comp = PRES_MIN;
    end else if (pdiv > 66'(PRES_MAX)) begin
      s11_nxt.pressure_comp = PRES_MAX;
    end else begin
      s11_nxt.pressure_comp = 40'(pdiv);
    end
    if (s10_r.temp < 21'(TEMP_MIN)) begin
      s11_nxt.temperature_centi = TEMP_MIN;
    end else if (s10_r.temp > 21'(TEMP_MAX)) begin
      s11_nxt.temperature_centi = TEMP_MAX;
    end else begin
      s11_nxt.temperature_centi = 19'(s10_r.temp);
    end
  end

  // Clear valid bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload registers on stage advance
  always_ff @(posedge clk) begin
    if (en[0]) s7_r  <= s7_nxt;
    if (en[1]) s8_r  <= s8_nxt;
    if (en[2]) s9_r  <= s9_nxt;
    if (en[3]) s10_r <= s10_nxt;
    if (en[4]) s11_r <= s11_nxt;
  end

endmodule
